FILE: sv/nsfp_pkg.sv
// shared constants and control types for the newline sensor frame parser
package nsfp_pkg;

  // number of sensor channels in one frame
  localparam int NUM_CHANNELS = 6;

  // store holds the data bytes plus the carriage-return slot
  localparam int STORE_DEPTH = 2 * NUM_CHANNELS + 1;
  // byte count saturates one past a full store
  localparam int COUNT_MAX   = STORE_DEPTH + 1;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int COUNT_W = $clog2(COUNT_MAX + 1);
  localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // fixed field widths
  localparam int BYTE_W    = 8;
  localparam int CHANNEL_W = 5;
  localparam int SAMPLE_W  = 16;

  localparam logic [BYTE_W-1:0]   TERMINATOR    = 8'h0A;
  localparam logic [SAMPLE_W-1:0] CONNECT_LIMIT = 16'd1023;

  // commands from controller to datapath
  typedef struct packed {
    logic wr_byte;    // store accepted data byte and bump count
    logic clr_count;  // terminator seen, restart frame
    logic ch_clr;     // start readout at channel zero
    logic ch_inc;     // advance to next channel
    logic rd_lo;      // read low byte of the current pair
    logic hi_load;    // capture high byte from read data
    logic out_load;   // load result register
  } nsfp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_term;    // input byte is the terminator
    logic count_full; // data plus carriage-return slot fill the store
    logic ch_last;    // current channel is the final one
    logic out_free;   // result register can take a new result
  } nsfp_stat_t;

endpackage

FILE: sv/nsfp_if.sv
// valid/ready channel interfaces for the byte input and the result output
interface nsfp_byte_if import nsfp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface nsfp_result_if import nsfp_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CHANNEL_W-1:0] channel;
  logic [SAMPLE_W-1:0]  sample;
  logic                 connected;
  logic                 last;

  modport source (output valid, output channel, output sample, output connected,
                  output last, input ready);
  modport sink   (input valid, input channel, input sample, input connected,
                  input last, output ready);
endinterface

FILE: sv/newline_sensor_frame_parser.sv
// top level of the newline-terminated sensor frame parser
//
// Takes one serial byte per beat on in_if and collects a frame up to a 0x0A
// terminator. The byte just before the terminator (carriage-return slot) is
// dropped; when exactly 2*NUM_CHANNELS data bytes remain, one result beat per
// channel leaves on out_if in channel order, each with the big-endian 16-bit
// sample, a connected flag (sample at most 1023) and last on the final
// channel. Frames of any other length, empty ones and overlong ones are
// dropped without output. A good terminator starts a readout through the single
// read port of the byte store, two reads per channel plus a load of the result
// register (read high byte, read low byte, then load the result, the load
// waiting while out_if stalls), and in_if is held off from the terminator beat
// until the final channel's result is loaded.
// The last result may still wait in the output register while the next
// frame's bytes are taken.
module newline_sensor_frame_parser import nsfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  nsfp_byte_if.sink            in_if,
  nsfp_result_if.source        out_if
);

  nsfp_cmd_t  cmd;
  nsfp_stat_t stat;

  // frame collection and readout sequencing
  nsfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // byte store, counters and the result register
  nsfp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_byte       (in_if.in_byte),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_channel   (out_if.channel),
    .out_sample    (out_if.sample),
    .out_connected (out_if.connected),
    .out_last      (out_if.last)
  );

endmodule

FILE: sv/nsfp_ctrl.sv
// controller state machine: byte collection and per-channel readout sequencing
module nsfp_ctrl import nsfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  nsfp_stat_t stat,
  output nsfp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RD_HI = 2'd1;
  localparam logic [1:0] S_RD_LO = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (stat.is_term) begin
            cmd.clr_count = 1'b1;
            if (stat.count_full) begin
              cmd.ch_clr = 1'b1;
              state_nxt  = S_RD_HI;
            end
          end else begin
            cmd.wr_byte = 1'b1;
          end
        end
      end
      S_RD_HI: begin
        state_nxt = S_RD_LO;
      end
      S_RD_LO: begin
        cmd.rd_lo   = 1'b1;
        cmd.hi_load = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        // keep the low byte on the read port while the result register is busy
        cmd.rd_lo = 1'b1;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.ch_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.ch_inc = 1'b1;
            state_nxt  = S_RD_HI;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/nsfp_dp.sv
// datapath: frame byte store, byte count, channel counter and result register
module nsfp_dp import nsfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [BYTE_W-1:0]    in_byte,
  input  nsfp_cmd_t            cmd,
  output nsfp_stat_t           stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CHANNEL_W-1:0] out_channel,
  output logic [SAMPLE_W-1:0]  out_sample,
  output logic                 out_connected,
  output logic                 out_last
);

  logic [BYTE_W-1:0]    store_mem [STORE_DEPTH];
  logic [COUNT_W-1:0]   count_r;
  logic [COUNT_W-1:0]   count_nxt;
  logic [CH_W-1:0]      ch_r;
  logic [CH_W-1:0]      ch_nxt;
  logic [ADDR_W-1:0]    rd_addr;
  logic [BYTE_W-1:0]    rd_data_r;
  logic [BYTE_W-1:0]    hi_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [CHANNEL_W-1:0] channel_r;
  logic [SAMPLE_W-1:0]  sample_r;
  logic                 connected_r;
  logic                 last_r;
  logic [SAMPLE_W-1:0]  sample_nxt;

  assign stat.is_term    = (in_byte == TERMINATOR);
  assign stat.count_full = (count_r == COUNT_W'(STORE_DEPTH));
  assign stat.ch_last    = (ch_r == CH_W'(NUM_CHANNELS - 1));
  assign stat.out_free   = !out_valid_r || out_ready;

  // byte store: write while collecting, registered read during readout
  always_ff @(posedge clk) begin
    if (cmd.wr_byte && (count_r < COUNT_W'(STORE_DEPTH))) begin
      store_mem[count_r[ADDR_W-1:0]] <= in_byte;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  assign rd_addr = ADDR_W'({ch_r, cmd.rd_lo});

  always_comb begin
    count_nxt = count_r;
    if (cmd.clr_count) begin
      count_nxt = '0;
    end else if (cmd.wr_byte && (count_r < COUNT_W'(COUNT_MAX))) begin
      count_nxt = count_r + COUNT_W'(1);
    end
  end

  always_comb begin
    ch_nxt = ch_r;
    if (cmd.ch_clr) begin
      ch_nxt = '0;
    end else if (cmd.ch_inc) begin
      ch_nxt = ch_r + CH_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign sample_nxt = {hi_r, rd_data_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hi_load) begin
      hi_r <= rd_data_r;
    end
    if (cmd.out_load) begin
      channel_r   <= CHANNEL_W'(ch_r);
      sample_r    <= sample_nxt;
      connected_r <= (sample_nxt <= CONNECT_LIMIT);
      last_r      <= stat.ch_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_channel   = channel_r;
  assign out_sample    = sample_r;
  assign out_connected = connected_r;
  assign out_last      = last_r;

endmodule

FILE: sv/nsfp_checker.sv
// port-level checks for the sensor frame parser, bound to the top level
module nsfp_checker import nsfp_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CHANNEL_W-1:0] out_channel,
  input logic [SAMPLE_W-1:0]  out_sample,
  input logic                 out_connected,
  input logic                 out_last
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) &&
    $stable(out_channel) && $stable(out_last))
    else $error("result beat changed while stalled");

  // last flags exactly the final channel
  a_last_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_channel == CHANNEL_W'(NUM_CHANNELS - 1))))
    else $error("last does not match final channel");

  // connected follows the sample limit
  a_connected: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_connected == (out_sample <= CONNECT_LIMIT)))
    else $error("connected flag wrong");

  // input is held off while a frame is still being read out
  a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken during readout");

  // no result right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind newline_sensor_frame_parser nsfp_checker u_nsfp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_channel   (out_if.channel),
  .out_sample    (out_if.sample),
  .out_connected (out_if.connected),
  .out_last      (out_if.last)
);

FILE: test/newline_sensor_frame_parser_test.sv
// testbench for the newline sensor frame parser: random framed traffic checked against a predictor
`timescale 1ns / 100ps

module newline_sensor_frame_parser_test import nsfp_pkg::*; ();

  // one result beat as the parser should deliver it
  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [SAMPLE_W-1:0]  sample;
    logic                 connected;
    logic                 last;
  } reading_t;

  // cycles without any beat on either side before the run is declared hung
  localparam int IDLE_LIMIT   = 3000;
  // long receiver hold-off, started once traffic is under way
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 40;
  // drain time after the last expected reading: one full readout plus margin
  localparam int DRAIN_CYCLES = 3 * NUM_CHANNELS + 24;
  localparam int TARGET_BYTES = 160;
  localparam int MIN_GOOD     = 8;
  localparam int MAX_WAIT     = 12;
  localparam logic [BYTE_W-1:0] CR_BYTE = 8'h0D;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  nsfp_byte_if   byte_bus ();
  nsfp_result_if result_bus ();

  newline_sensor_frame_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (byte_bus),
    .out_if (result_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // bytes waiting to be offered, filled up front by the stimulus block
  logic [BYTE_W-1:0] byte_q[$];
  // readings the parser owes us, oldest first
  reading_t          readings_due[$];

  // private copy of the parser's frame state
  logic [BYTE_W-1:0]  frame_mem [STORE_DEPTH];
  logic [COUNT_W-1:0] frame_len = '0;

  int bytes_total    = 0;
  int bytes_taken    = 0;
  int mismatch_count = 0;
  int idle_cycles    = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  // drive everything known before the first edge
  initial begin
    byte_bus.valid    = 1'b0;
    byte_bus.in_byte  = '0;
    result_bus.ready  = 1'b0;
  end

  // mirror of the parser: store data bytes, saturate the count, and on a
  // terminator with a full store queue one reading per channel
  function automatic void parse_byte(input logic [BYTE_W-1:0] b);
    reading_t r;
    if (b != TERMINATOR) begin
      if (frame_len < STORE_DEPTH) frame_mem[frame_len] = b;
      if (frame_len < COUNT_MAX) frame_len = frame_len + 1'b1;
    end else begin
      // carriage-return slot is the 13th byte and is simply not read
      if (frame_len == STORE_DEPTH) begin
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
          r.channel   = CHANNEL_W'(ch);
          r.sample    = {frame_mem[2*ch], frame_mem[2*ch+1]};
          r.connected = (r.sample <= CONNECT_LIMIT);
          r.last      = (ch == NUM_CHANNELS - 1);
          readings_due.push_back(r);
        end
      end
      frame_len = '0;
    end
  endfunction

  function automatic int draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // byte that is never taken as a terminator
  function automatic logic [BYTE_W-1:0] fix_term(input logic [BYTE_W-1:0] b);
    return (b == TERMINATOR) ? (b ^ 8'h01) : b;
  endfunction

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    byte_q.push_back(b);
    bytes_total++;
  endtask

  // well-formed frame: six samples, cr slot, terminator
  task automatic queue_good_frame();
    logic [SAMPLE_W-1:0] s;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      case ($urandom_range(0, 3))
        0:       s = SAMPLE_W'($urandom_range(0, 1023));
        1:       s = $urandom_range(0, 1) ? 16'd1023 : 16'd1024;
        2:       s = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default: s = SAMPLE_W'($urandom);
      endcase
      queue_byte(fix_term(s[15:8]));
      queue_byte(fix_term(s[7:0]));
    end
    queue_byte($urandom_range(0, 3) == 0 ? fix_term(BYTE_W'($urandom)) : CR_BYTE);
    queue_byte(TERMINATOR);
  endtask

  // driver: one byte per item, random gap after each accepted beat
  int send_wait  = 0;
  bit send_burst = 1'b0;
  always @(posedge clk) begin
    logic              offer;
    logic [BYTE_W-1:0] data;
    if (!rst_n) begin
      byte_bus.valid   <= 1'b0;
      byte_bus.in_byte <= '0;
      send_wait        = 0;
    end else begin
      offer = byte_bus.valid;
      data  = byte_bus.in_byte;
      if (byte_bus.valid && byte_bus.ready) begin
        parse_byte(byte_bus.in_byte);
        bytes_taken <= bytes_taken + 1;
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (byte_q.size() > 0) begin
          offer = 1'b1;
          data  = byte_q.pop_front();
          if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
          send_wait = draw_wait(send_burst);
        end
      end
      // single assignment per edge keeps a held valid steady
      byte_bus.valid   <= offer;
      byte_bus.in_byte <= data;
    end
  end

  // long receiver hold-off so the readout backs up and the input stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && bytes_taken >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks every accepted result beat against the oldest reading owed
  int       stall_left  = 0;
  bit       recv_burst  = 1'b0;
  always @(posedge clk) begin
    reading_t want;
    logic     take;
    if (!rst_n) begin
      result_bus.ready <= 1'b0;
      stall_left       = 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (readings_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat channel=%0d sample=%h",
                                    result_bus.channel, result_bus.sample));
        end else begin
          want = readings_due.pop_front();
          if (result_bus.channel !== want.channel)
            report_mismatch($sformatf("channel expected %0d got %0d",
                                      want.channel, result_bus.channel));
          if (result_bus.sample !== want.sample)
            report_mismatch($sformatf("sample ch%0d expected %h got %h",
                                      want.channel, want.sample, result_bus.sample));
          if (result_bus.connected !== want.connected)
            report_mismatch($sformatf("connected ch%0d expected %b got %b",
                                      want.channel, want.connected, result_bus.connected));
          if (result_bus.last !== want.last)
            report_mismatch($sformatf("last ch%0d expected %b got %b",
                                      want.channel, want.last, result_bus.last));
        end
        if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
        stall_left = draw_wait(recv_burst);
      end
      if (hold_left > 0) begin
        take = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      result_bus.ready <= take;
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (byte_bus.valid && byte_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("newline_sensor_frame_parser_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    int good_frames;
    int len;
    good_frames = 0;

    // empty frame: bare terminator
    queue_byte(TERMINATOR);
    // good frame with boundary samples: zero, 1023, 1024, all ones, plus 0x00FF and 0x8001
    queue_byte(8'h00); queue_byte(8'h00);
    queue_byte(8'h03); queue_byte(8'hFF);
    queue_byte(8'h04); queue_byte(8'h00);
    queue_byte(8'hFF); queue_byte(8'hFF);
    queue_byte(8'h00); queue_byte(8'hFF);
    queue_byte(8'h80); queue_byte(8'h01);
    queue_byte(CR_BYTE);
    queue_byte(TERMINATOR);
    // wrong length
    queue_byte(8'h55); queue_byte(8'hAA); queue_byte(CR_BYTE);
    queue_byte(TERMINATOR);
    // data byte equal to the terminator cuts the frame short
    queue_byte(8'h12);
    queue_byte(TERMINATOR);

    // random part: mostly good frames, the rest broken ones and noise
    while (bytes_total < TARGET_BYTES || good_frames < MIN_GOOD) begin
      case ($urandom_range(0, 9))
        7: begin
          // wrong length, including one short and one past the cr slot
          len = $urandom_range(0, STORE_DEPTH + 1);
          if (len == STORE_DEPTH) len = STORE_DEPTH - 1;
          repeat (len) queue_byte(fix_term(BYTE_W'($urandom)));
          queue_byte(TERMINATOR);
        end
        8: begin
          // overlong: count saturates and the frame is dropped
          len = $urandom_range(COUNT_MAX + 1, COUNT_MAX + 6);
          repeat (len) queue_byte(fix_term(BYTE_W'($urandom)));
          queue_byte(TERMINATOR);
        end
        9: begin
          // raw noise, terminators allowed, then resync
          len = $urandom_range(1, 8);
          repeat (len) queue_byte($urandom_range(0, 3) == 0 ? TERMINATOR : BYTE_W'($urandom));
          queue_byte(TERMINATOR);
        end
        default: begin
          queue_good_frame();
          good_frames++;
        end
      endcase
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken != bytes_total) @(posedge clk);
    while (readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("newline_sensor_frame_parser_test: PASS");
    end else begin
      $display("newline_sensor_frame_parser_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/nsfp_pkg.sv
sv/nsfp_if.sv
sv/nsfp_ctrl.sv
sv/nsfp_dp.sv
sv/newline_sensor_frame_parser.sv
sv/nsfp_checker.sv
test/newline_sensor_frame_parser_test.sv
